// ----- rtl/core/first_fit_virtual_range_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// first_fit_virtual_range_allocator_macros
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_VIRTUAL_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_VIRTUAL_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, reset-qualified
`define FFVRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-qualified
`define FFVRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ffvra_pkg.sv -----
// ----------------------------------------------------------------------------
// ffvra_pkg
// Transfer types and codes of the first-fit virtual range allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffvra_pkg;

    localparam logic       ACT_ALLOC    = 1'b0;
    localparam logic       ACT_FREE     = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO      = 2'd1;
    localparam logic [1:0] ST_NOROOM    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND  = 2'd3;

    typedef struct packed {
        logic        action;
        logic [31:0] size_bytes;
        logic [63:0] area_address;
    } t_req;

    typedef struct packed {
        logic [63:0] base_address;
        logic [1:0]  status;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/core/ffvra_mem.sv -----
// ----------------------------------------------------------------------------
// ffvra_mem
// Area table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ffvra_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 73
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_virtual_range_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_virtual_range_allocator
// First-fit allocator of page-rounded virtual address areas.
// ----------------------------------------------------------------------------
// Request channel: i_in_valid / o_in_stall with i_in_data (action, size in
// bytes, address to free). Response channel: o_out_valid / i_out_stall with
// o_out_data (base address, status). One response per request.
// The area table sits in a single-port-read, single-port-write memory and is
// walked one entry per cycle. The scan stops where the shift starts. Zero
// size, full table and free on an empty table skip the walk and go straight
// to the response; the first alloc skips the scan. The next transfer is
// taken in the cycle after the response is loaded. One request is in
// flight at a time; o_in_stall is high while it is worked.
// A finished response waits in the output register while i_out_stall is
// high, and the next request may already be taken meanwhile; its response
// then holds the block, input stalled, until the output register frees.
// Reset empties the table (count to zero, no memory sweep) and clears
// region_start. i_cfg_we writes region_start; it matters only when empty.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_virtual_range_allocator #(
    parameter int MAX_AREAS  = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [63:0]       i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ffvra_pkg::t_req   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ffvra_pkg::t_rsp        o_out_data
);
    import ffvra_pkg::*;

    `include "first_fit_virtual_range_allocator_macros.svh"

    localparam int PBL  = $clog2(PAGE_BYTES);
    localparam int BPW  = 64 - PBL;
    localparam int CW   = 33 - PBL;
    localparam int AW   = $clog2(MAX_AREAS);
    localparam int CNTW = $clog2(MAX_AREAS + 1);
    localparam int EW   = BPW + CW;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_SHUP   = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam logic [BPW+1:0] LIMIT = (BPW+2)'(1) << BPW;

    logic [2:0]      r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [63:0]     r_region;
    logic            r_act, n_act;
    logic [CW-1:0]   r_pages, n_pages;
    logic [63:0]     r_addr, n_addr;
    logic [CNTW-1:0] r_ra, n_ra;
    logic            r_iss, n_iss;
    logic            r_dv, n_dv;
    logic [AW-1:0]   r_di, n_di;
    logic [BPW:0]    r_prev_end, n_prev_end;
    logic [BPW:0]    r_base, n_base;
    logic [CNTW-1:0] r_pos, n_pos;
    logic [1:0]      r_status, n_status;
    logic            r_ovld, n_ovld;
    t_rsp            r_odata, n_odata;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata, mem_rdata;
    logic [BPW-1:0]  e_base;
    logic [CW-1:0]   e_cnt;
    logic [BPW:0]    e_end;
    logic [32:0]     req_sum;
    logic [BPW+1:0]  fit_sum, ovf_sum;
    logic            di_last;

    assign e_base  = mem_rdata[EW-1:CW];
    assign e_cnt   = mem_rdata[CW-1:0];
    assign e_end   = {1'b0, e_base} + (BPW+1)'(e_cnt);
    assign req_sum = {1'b0, i_in_data.size_bytes} + 33'(PAGE_BYTES - 1);
    assign fit_sum = {1'b0, r_prev_end} + (BPW+2)'(r_pages);
    assign ovf_sum = {1'b0, r_base} + (BPW+2)'(r_pages);
    assign di_last = (CNTW'(r_di) == r_count - CNTW'(1));

    ffvra_mem #(
        .DEPTH (MAX_AREAS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_ra[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_act      = r_act;
        n_pages    = r_pages;
        n_addr     = r_addr;
        n_ra       = r_ra;
        n_iss      = r_iss;
        n_dv       = 1'b0;
        n_di       = r_di;
        n_prev_end = r_prev_end;
        n_base     = r_base;
        n_pos      = r_pos;
        n_status   = r_status;
        n_odata    = r_odata;
        n_ovld     = r_ovld & i_out_stall;
        mem_we     = 1'b0;
        mem_waddr  = r_di;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_in_data.action;
                    n_pages = req_sum[32:PBL];
                    n_addr  = i_in_data.area_address;
                    n_ra    = '0;
                    n_iss   = 1'b1;
                    if (i_in_data.action == ACT_ALLOC) begin
                        if (i_in_data.size_bytes == 32'd0) begin
                            n_status = ST_ZERO;
                            n_state  = S_OUT;
                        end else if (r_count == CNTW'(MAX_AREAS)) begin
                            n_status = ST_NOROOM;
                            n_state  = S_OUT;
                        end else if (r_count == '0) begin
                            n_base  = {1'b0, r_region[63:PBL]};
                            n_pos   = '0;
                            n_state = S_CHECK;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_dv) begin
                    if (r_act == ACT_ALLOC) begin
                        if (r_di != '0 && fit_sum <= (BPW+2)'(e_base)) begin
                            n_base  = r_prev_end;
                            n_pos   = CNTW'(r_di);
                            n_state = S_CHECK;
                        end else begin
                            n_prev_end = e_end;
                            if (di_last) begin
                                n_base  = e_end;
                                n_pos   = r_count;
                                n_state = S_CHECK;
                            end
                        end
                    end else begin
                        if (r_addr[PBL-1:0] == '0 && r_addr[63:PBL] == e_base) begin
                            n_pos = CNTW'(r_di);
                            if (di_last) begin
                                n_count  = r_count - CNTW'(1);
                                n_status = ST_OK;
                                n_state  = S_OUT;
                            end else begin
                                n_ra    = CNTW'(r_di) + CNTW'(1);
                                n_iss   = 1'b1;
                                n_state = S_SHDN;
                            end
                        end else if (di_last) begin
                            n_status = ST_NOTFOUND;
                            n_state  = S_OUT;
                        end
                    end
                end
                if (r_iss && n_state == S_SCAN) begin
                    mem_re = 1'b1;
                    n_dv   = 1'b1;
                    n_di   = r_ra[AW-1:0];
                    n_ra   = r_ra + CNTW'(1);
                    n_iss  = (r_ra + CNTW'(1) < r_count);
                end
            end
            S_CHECK: begin
                if (ovf_sum > LIMIT) begin
                    n_status = ST_NOROOM;
                    n_state  = S_OUT;
                end else if (r_pos == r_count) begin
                    n_state = S_INSERT;
                end else begin
                    n_ra    = r_count - CNTW'(1);
                    n_iss   = 1'b1;
                    n_state = S_SHUP;
                end
            end
            S_SHUP: begin
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_di + AW'(1);
                    if (CNTW'(r_di) == r_pos) begin
                        n_state = S_INSERT;
                    end
                end
                if (r_iss) begin
                    mem_re = 1'b1;
                    n_dv   = 1'b1;
                    n_di   = r_ra[AW-1:0];
                    n_ra   = r_ra - CNTW'(1);
                    n_iss  = (r_ra != r_pos);
                end
            end
            S_SHDN: begin
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_di - AW'(1);
                    if (di_last) begin
                        n_count  = r_count - CNTW'(1);
                        n_status = ST_OK;
                        n_state  = S_OUT;
                    end
                end
                if (r_iss) begin
                    mem_re = 1'b1;
                    n_dv   = 1'b1;
                    n_di   = r_ra[AW-1:0];
                    n_ra   = r_ra + CNTW'(1);
                    n_iss  = (r_ra + CNTW'(1) < r_count);
                end
            end
            S_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = {r_base[BPW-1:0], r_pages};
                n_count   = r_count + CNTW'(1);
                n_status  = ST_OK;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_ovld || !i_out_stall) begin
                    n_ovld         = 1'b1;
                    n_odata.status = r_status;
                    if (r_act == ACT_ALLOC && r_status == ST_OK) begin
                        n_odata.base_address = {r_base[BPW-1:0], {PBL{1'b0}}};
                    end else begin
                        n_odata.base_address = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_region <= '0;
            r_iss    <= 1'b0;
            r_dv     <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_iss   <= n_iss;
            r_dv    <= n_dv;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                r_region <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_pages    <= n_pages;
        r_addr     <= n_addr;
        r_ra       <= n_ra;
        r_di       <= n_di;
        r_prev_end <= n_prev_end;
        r_base     <= n_base;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_odata    <= n_odata;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_odata;

    `FFVRA_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNTW'(MAX_AREAS), "area count overflow")
    `FFVRA_ASSERT_NEXT(a_count_idle, r_state == S_IDLE, $stable(r_count), "count moved when idle")
    `FFVRA_ASSERT_NOW(a_shift_room, r_state == S_SHUP, r_count < CNTW'(MAX_AREAS), "shift on full table")

endmodule
`default_nettype wire

// ----- sim/tb_first_fit_virtual_range_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_virtual_range_allocator
// Self-checking bench for the first-fit virtual range allocator.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the area table and works out each response
// from it. Directed tests cover the region start register, size rounding,
// gap reuse, a full table, address overflow and frees that match no area.
// A random part then mixes well-formed alloc/free traffic with noise under
// several region settings. Both sides idle at random. Each response is
// compared field by field against the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_first_fit_virtual_range_allocator;
    import ffvra_pkg::*;

    localparam int          AREAS     = 64;
    localparam int          PG_SHIFT  = 12;
    localparam logic [63:0] PG_LIMIT  = 64'h1 << 52;
    localparam longint      CYC_LIMIT = 3_000_000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_cfg_we = 1'b0;
    logic   [63:0] i_cfg_wdata = '0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_req   i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_rsp   o_out_data;

    first_fit_virtual_range_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // area table as the block should hold it
    logic [63:0] tbl_base_page [AREAS];
    logic [63:0] tbl_pages     [AREAS];
    int          tbl_count;
    logic [63:0] region_start;

    t_rsp   expected_rsp [$];
    int     fail_count;
    longint cycle_count;
    bit     no_idle;
    int     stall_left;
    int     status_seen [4];

    function automatic t_rsp model_request(t_req r);
        t_rsp        o;
        logic [63:0] pages;
        logic [63:0] base;
        logic [63:0] area_end;
        int          pos;
        o.base_address = '0;
        o.status       = ST_OK;
        if (r.action == ACT_ALLOC) begin
            if (r.size_bytes == 0) begin
                o.status = ST_ZERO;
            end else if (tbl_count >= AREAS) begin
                o.status = ST_NOROOM;
            end else begin
                pages = ({32'b0, r.size_bytes} + 64'd4095) >> PG_SHIFT;
                if (tbl_count == 0) begin
                    base = region_start >> PG_SHIFT;
                    pos  = 0;
                end else begin
                    pos  = tbl_count;
                    base = tbl_base_page[tbl_count-1] + tbl_pages[tbl_count-1];
                    for (int k = 0; k + 1 < tbl_count; k++) begin
                        area_end = tbl_base_page[k] + tbl_pages[k];
                        if (area_end + pages <= tbl_base_page[k+1]) begin
                            base = area_end;
                            pos  = k + 1;
                            break;
                        end
                    end
                end
                if (base > PG_LIMIT || pages > PG_LIMIT - base) begin
                    o.status = ST_NOROOM;
                end else begin
                    for (int k = tbl_count; k > pos; k--) begin
                        tbl_base_page[k] = tbl_base_page[k-1];
                        tbl_pages[k]     = tbl_pages[k-1];
                    end
                    tbl_base_page[pos] = base;
                    tbl_pages[pos]     = pages;
                    tbl_count++;
                    o.base_address = base << PG_SHIFT;
                end
            end
        end else begin
            o.status = ST_NOTFOUND;
            for (int k = 0; k < tbl_count; k++) begin
                if ((tbl_base_page[k] << PG_SHIFT) == r.area_address) begin
                    for (int m = k; m + 1 < tbl_count; m++) begin
                        tbl_base_page[m] = tbl_base_page[m+1];
                        tbl_pages[m]     = tbl_pages[m+1];
                    end
                    tbl_count--;
                    o.status = ST_OK;
                    break;
                end
            end
        end
        return o;
    endfunction

    task automatic send_request(t_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        expected_rsp.push_back(model_request(r));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (2 * AREAS + 10) @(posedge i_clk);
    endtask

    task automatic write_region(logic [63:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        region_start = value;
    endtask

    function automatic t_req alloc_req(logic [31:0] size);
        t_req r;
        r.action       = ACT_ALLOC;
        r.size_bytes   = size;
        r.area_address = {$urandom, $urandom};
        return r;
    endfunction

    function automatic t_req free_req(logic [63:0] addr);
        t_req r;
        r.action       = ACT_FREE;
        r.size_bytes   = $urandom;
        r.area_address = addr;
        return r;
    endfunction

    task automatic free_all();
        while (tbl_count > 0)
            send_request(free_req(tbl_base_page[$urandom_range(0, tbl_count-1)] << PG_SHIFT));
    endtask

    task automatic test_basic_sizes();
        send_request(free_req(64'h0));
        send_request(alloc_req(32'd0));
        send_request(alloc_req(32'd1));
        send_request(alloc_req(32'd4096));
        send_request(alloc_req(32'd4097));
        send_request(alloc_req(32'hFFFF_FFFF));
        send_request(free_req(64'h1001));
        send_request(free_req(64'hFFFF_FFFF_FFFF_FFFF));
        free_all();
    endtask

    task automatic test_gap_reuse();
        write_region(64'h0000_0000_1234_5ABC);
        send_request(alloc_req(32'd8192));
        send_request(alloc_req(32'd12288));
        send_request(alloc_req(32'd4096));
        send_request(free_req(tbl_base_page[1] << PG_SHIFT));
        send_request(alloc_req(32'd16384));
        send_request(alloc_req(32'd4000));
        send_request(alloc_req(32'd8192));
        send_request(free_req(tbl_base_page[0] << PG_SHIFT));
        send_request(alloc_req(32'd4096));
        free_all();
    endtask

    task automatic test_full_table();
        no_idle = 1'b1;
        repeat (AREAS) send_request(alloc_req($urandom_range(1, 20000)));
        send_request(alloc_req(32'd1));
        no_idle = 1'b0;
        free_all();
    endtask

    task automatic test_overflow();
        write_region(64'hFFFF_FFFF_FFFF_F000);
        send_request(alloc_req(32'd4096));
        send_request(alloc_req(32'd1));
        free_all();
        send_request(alloc_req(32'hFFFF_FFFF));
        write_region(64'hFFFF_FFFF_0000_0FFF);
        send_request(alloc_req(32'hFFFF_FFFF));
        send_request(alloc_req(32'h0010_0000));
        // register written with areas present: the table must ignore it
        write_region(64'h0);
        send_request(alloc_req(32'd1));
        free_all();
    endtask

    task automatic random_phase(int n);
        t_req        r;
        int          alloc_pct;
        int          pick;
        logic [31:0] size;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            alloc_pct = tbl_count < 8 ? 75 : (tbl_count > 56 ? 30 : 52);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                r = free_req({$urandom, $urandom});
            end else if (pick < 7) begin
                r = alloc_req(32'd0);
            end else if (pick < 7 + alloc_pct || tbl_count == 0) begin
                case ($urandom_range(0, 9))
                    0, 1:    size = $urandom;
                    2, 3:    size = $urandom_range(1, 16) << PG_SHIFT;
                    default: size = $urandom_range(1, 20000);
                endcase
                if (size == 0) size = 1;
                r = alloc_req(size);
            end else begin
                r = free_req(tbl_base_page[$urandom_range(0, tbl_count-1)] << PG_SHIFT);
            end
            send_request(r);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        random_phase(400);
        free_all();
        write_region(64'h0000_7FFF_0000_0000);
        random_phase(400);
        free_all();
        write_region(64'hFFFF_FFFF_F000_0000);
        random_phase(250);
        free_all();
        write_region({$urandom, $urandom});
        random_phase(250);
    endtask

    // response side: random stall, compare each transfer
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_rsp.size() == 0) begin
                $error("unexpected response base=%h status=%0d",
                       o_out_data.base_address, o_out_data.status);
                fail_count++;
            end else begin
                e = expected_rsp.pop_front();
                status_seen[e.status]++;
                if (o_out_data.base_address !== e.base_address) begin
                    $error("base_address expected %h got %h",
                           e.base_address, o_out_data.base_address);
                    fail_count++;
                end
                if (o_out_data.status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_out_data.status);
                    fail_count++;
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        stall_left   = 0;
        no_idle      = 1'b0;
        tbl_count    = 0;
        region_start = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_sizes();
        test_gap_reuse();
        test_full_table();
        test_overflow();
        test_random();
        wait_idle();
        $display("Covered alloc/free traffic over several region starts: ok %0d, zero %0d,",
                 status_seen[ST_OK], status_seen[ST_ZERO]);
        $display("  no room or overflow %0d, free not found %0d; %0d mismatches",
                 status_seen[ST_NOROOM], status_seen[ST_NOTFOUND], fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
